// ----- rtl/core/i2cmtrw_pkg.sv -----
// Shared types and constants for the multi-target I2C register window.
`timescale 1ns / 1ps
package i2cmtrw_pkg;

  localparam int NUM_DEVICES_DEF = 2;
  localparam int MAX_REGS_DEF    = 256;

  // Devices with a configuration slot
  localparam int CFG_DEVS = 2;

  localparam int POS_W = 17;
  localparam logic [POS_W-1:0] POS_MAX = 17'h1FFFF;

  localparam int CFG_AW = 5;
  localparam int CFG_DW = 32;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_DEVICE_COUNT = 3'd0;
  localparam logic [2:0] REG_DEV0_ADDRESS = 3'd1;
  localparam logic [2:0] REG_DEV0_BASE    = 3'd2;
  localparam logic [2:0] REG_DEV0_SIZE    = 3'd3;
  localparam logic [2:0] REG_DEV1_ADDRESS = 3'd4;
  localparam logic [2:0] REG_DEV1_BASE    = 3'd5;
  localparam logic [2:0] REG_DEV1_SIZE    = 3'd6;

  // Request kinds
  typedef enum logic [2:0] {
    FN_START    = 3'd0,
    FN_WRITE    = 3'd1,
    FN_READ     = 3'd2,
    FN_END_MSG  = 3'd3,
    FN_END_XFER = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FAIL    = 2'd1,
    STAT_IGNORED = 2'd2
  } status_t;

  typedef struct packed {
    logic we;
    logic re;
  } store_cmd_t;

endpackage

// ----- rtl/core/i2cmtrw_store.sv -----
// Register byte store: one-port synchronous memory with a clearing pass after reset.
`timescale 1ns / 1ps
module i2cmtrw_store
  import i2cmtrw_pkg::*;
#(
  parameter int DEPTH = NUM_DEVICES_DEF * MAX_REGS_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          rst,
  input  store_cmd_t    cmd,
  input  logic [AW-1:0] addr,
  input  logic [7:0]    wdata,
  output logic [7:0]    rdata,
  output logic          ready
);

  logic [7:0]    mem [DEPTH];
  logic [AW-1:0] clr_addr;
  logic          clearing;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
      clearing <= 1'b1;
    end else if (clearing) begin
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
      clr_addr <= clr_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (clearing) begin
      mem[clr_addr] <= 8'h00;
    end else if (cmd.we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.re) begin
      rdata <= mem[addr];
    end
  end

  assign ready = !clearing;

endmodule

// ----- rtl/core/i2c_multi_target_register_window_unit.sv -----
// Top level: configuration registers, transfer control and result register.
// Result path: an accepted request registers its store read and enters ST_RESP, which
// loads the result and sets m_tvalid; s_tready is low in ST_RESP and while a result waits.
// Reset: rst is synchronous; afterwards the byte store is cleared one entry per cycle,
// NUM_DEVICES*MAX_REGS entries, with s_tready low; configuration writes are taken throughout.
`timescale 1ns / 1ps
module i2c_multi_target_register_window_unit
  import i2cmtrw_pkg::*;
#(
  parameter int NUM_DEVICES = NUM_DEVICES_DEF,
  parameter int MAX_REGS    = MAX_REGS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  // request stream
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [23:0]       s_tdata,  // target_address[9:0], is_read[10], data_byte[18:11]
  input  logic [2:0]        s_tuser,  // func[2:0]
  // result stream
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [79:0]       m_tdata,  // read_byte[7:0], item_status[9:8], transfer_ok[10],
                                      // success_count[42:11], failure_count[74:43]
  output logic              m_tlast,  // transfer_done
  // configuration
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  localparam int DEPTH = NUM_DEVICES * MAX_REGS;
  localparam int AW    = $clog2(DEPTH);
  localparam int OFF_W = $clog2(MAX_REGS);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RESP = 2'b10
  } state_t;

  // configuration
  logic [1:0]  dev_count;
  logic [9:0]  dev_address [CFG_DEVS];
  logic [15:0] dev_base    [CFG_DEVS];
  logic [8:0]  dev_size    [CFG_DEVS];
  logic [2:0]  cfg_idx;
  logic        cfg_we;

  // transfer state
  logic [15:0]      reg_ptr [CFG_DEVS];
  logic [15:0]      reg_ptr_next [CFG_DEVS];
  logic             message_open, message_open_next;
  logic             message_reading, message_reading_next;
  logic             current_device, current_device_next;
  logic [POS_W-1:0] byte_position, byte_position_next;
  logic [7:0]       high_byte, high_byte_next;
  logic             transfer_failed, transfer_failed_next;
  logic             messages_seen, messages_seen_next;
  logic [31:0]      success_total, success_total_next;
  logic [31:0]      failure_total, failure_total_next;

  state_t run_state;

  // request fields
  logic [2:0] func;
  logic [9:0] target_address;
  logic       is_read;
  logic [7:0] data_byte;
  logic       in_acc;

  // step logic
  logic [2:0]       act_n;
  logic             hit;
  logic             hit_dev;
  logic [POS_W-1:0] pos_k;
  logic [POS_W-1:0] pos_adv;
  logic [18:0]      diff;
  logic             in_window;
  logic [OFF_W-1:0] off;
  logic [AW-1:0]    st_addr;
  store_cmd_t       st_cmd;
  status_t          status;
  logic             done;
  logic             ok;
  logic             fail;
  logic             rd_hit;

  // result
  status_t     resp_status;
  logic        resp_done;
  logic        resp_ok;
  logic        resp_rd;
  logic [7:0]  st_rdata;
  logic        st_ready;
  logic [7:0]  out_byte;
  status_t     out_status;
  logic        out_done;
  logic        out_ok;
  logic [31:0] out_succ;
  logic [31:0] out_fail;

  assign func           = s_tuser;
  assign target_address = s_tdata[9:0];
  assign is_read        = s_tdata[10];
  assign data_byte      = s_tdata[18:11];

  assign s_tready = (run_state == ST_IDLE) && st_ready && (!m_tvalid || m_tready);
  assign in_acc   = s_tvalid && s_tready;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_idx = paddr[4:2];
  assign cfg_we  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      dev_count <= '0;
      for (int i = 0; i < CFG_DEVS; i++) begin
        dev_address[i] <= '0;
        dev_base[i]    <= '0;
        dev_size[i]    <= '0;
      end
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_DEVICE_COUNT: dev_count      <= pwdata[1:0];
        REG_DEV0_ADDRESS: dev_address[0] <= pwdata[9:0];
        REG_DEV0_BASE:    dev_base[0]    <= pwdata[15:0];
        REG_DEV0_SIZE:    dev_size[0]    <= pwdata[8:0];
        REG_DEV1_ADDRESS: dev_address[1] <= pwdata[9:0];
        REG_DEV1_BASE:    dev_base[1]    <= pwdata[15:0];
        REG_DEV1_SIZE:    dev_size[1]    <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_DEVICE_COUNT: prdata = CFG_DW'(dev_count);
      REG_DEV0_ADDRESS: prdata = CFG_DW'(dev_address[0]);
      REG_DEV0_BASE:    prdata = CFG_DW'(dev_base[0]);
      REG_DEV0_SIZE:    prdata = CFG_DW'(dev_size[0]);
      REG_DEV1_ADDRESS: prdata = CFG_DW'(dev_address[1]);
      REG_DEV1_BASE:    prdata = CFG_DW'(dev_base[1]);
      REG_DEV1_SIZE:    prdata = CFG_DW'(dev_size[1]);
      default:          prdata = '0;
    endcase
  end

  // ---------------- address match and window ----------------
  always_comb begin
    act_n = {1'b0, dev_count};
    if (act_n > 3'(NUM_DEVICES)) act_n = 3'(NUM_DEVICES);
    if (act_n > 3'(CFG_DEVS))    act_n = 3'(CFG_DEVS);
    hit     = 1'b0;
    hit_dev = 1'b0;
    for (int i = 0; i < CFG_DEVS; i++) begin
      if (!hit && (3'(i) < act_n) && (dev_address[i] == target_address)) begin
        hit     = 1'b1;
        hit_dev = 1'(i);
      end
    end
  end

  // payload offset: write bytes follow the two pointer bytes
  assign pos_k   = (func == FN_WRITE) ? byte_position - POS_W'(2) : byte_position;
  assign pos_adv = (byte_position == POS_MAX) ? byte_position : byte_position + 1'b1;

  // pointer + offset - base, 19-bit two's complement; negative means below the window
  assign diff = 19'(reg_ptr[current_device]) + 19'(pos_k) - 19'(dev_base[current_device]);
  assign in_window = !diff[18]
                     && (diff[17:0] < 18'(dev_size[current_device]))
                     && (diff[17:0] < 18'(MAX_REGS))
                     && ((NUM_DEVICES > 1) || !current_device);
  assign off     = diff[OFF_W-1:0];
  assign st_addr = AW'(off) + (current_device ? AW'(MAX_REGS) : AW'(0));

  // ---------------- step logic ----------------
  always_comb begin
    for (int i = 0; i < CFG_DEVS; i++) reg_ptr_next[i] = reg_ptr[i];
    message_open_next    = message_open;
    message_reading_next = message_reading;
    current_device_next  = current_device;
    byte_position_next   = byte_position;
    high_byte_next       = high_byte;
    transfer_failed_next = transfer_failed;
    messages_seen_next   = messages_seen;
    success_total_next   = success_total;
    failure_total_next   = failure_total;
    status = STAT_OK;
    done   = 1'b0;
    ok     = 1'b0;
    fail   = 1'b0;
    rd_hit = 1'b0;
    st_cmd = '0;

    if (func == FN_END_XFER) begin
      done = 1'b1;
      if (transfer_failed) begin
        status = STAT_IGNORED;
      end else if (!messages_seen || message_open) begin
        status = STAT_FAIL;
      end else begin
        ok = 1'b1;
      end
      if (ok) success_total_next = success_total + 1'b1;
      else    failure_total_next = failure_total + 1'b1;
      message_open_next    = 1'b0;
      message_reading_next = 1'b0;
      byte_position_next   = '0;
      transfer_failed_next = 1'b0;
      messages_seen_next   = 1'b0;
    end else if (transfer_failed) begin
      status = STAT_IGNORED;
    end else begin
      case (func)
        FN_START: begin
          messages_seen_next = 1'b1;
          if (message_open || !hit) begin
            fail = 1'b1;
          end else begin
            current_device_next  = hit_dev;
            message_open_next    = 1'b1;
            message_reading_next = is_read;
            byte_position_next   = '0;
          end
        end
        FN_WRITE: begin
          if (!message_open || message_reading) begin
            fail = 1'b1;
          end else if (byte_position == '0) begin
            high_byte_next     = data_byte;
            byte_position_next = pos_adv;
          end else if (byte_position == POS_W'(1)) begin
            reg_ptr_next[current_device] = {high_byte, data_byte};
            byte_position_next = pos_adv;
          end else if (in_window) begin
            st_cmd.we          = 1'b1;
            byte_position_next = pos_adv;
          end else begin
            fail = 1'b1;
          end
        end
        FN_READ: begin
          if (!message_open || !message_reading || !in_window) begin
            fail = 1'b1;
          end else begin
            st_cmd.re          = 1'b1;
            rd_hit             = 1'b1;
            byte_position_next = pos_adv;
          end
        end
        FN_END_MSG: begin
          if (!message_open) begin
            fail = 1'b1;
          end else if (message_reading) begin
            reg_ptr_next[current_device] = reg_ptr[current_device] + byte_position[15:0];
            message_open_next  = 1'b0;
            byte_position_next = '0;
          end else if (byte_position < POS_W'(2)) begin
            fail = 1'b1;
          end else begin
            // payload length excludes the two pointer bytes
            reg_ptr_next[current_device] = reg_ptr[current_device]
                                           + (byte_position[15:0] - 16'd2);
            message_open_next  = 1'b0;
            byte_position_next = '0;
          end
        end
        default: fail = 1'b1;
      endcase
      if (fail) begin
        status               = STAT_FAIL;
        transfer_failed_next = 1'b1;
        message_open_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CFG_DEVS; i++) reg_ptr[i] <= '0;
      message_open    <= 1'b0;
      message_reading <= 1'b0;
      current_device  <= 1'b0;
      byte_position   <= '0;
      high_byte       <= '0;
      transfer_failed <= 1'b0;
      messages_seen   <= 1'b0;
      success_total   <= '0;
      failure_total   <= '0;
    end else if (in_acc) begin
      for (int i = 0; i < CFG_DEVS; i++) reg_ptr[i] <= reg_ptr_next[i];
      message_open    <= message_open_next;
      message_reading <= message_reading_next;
      current_device  <= current_device_next;
      byte_position   <= byte_position_next;
      high_byte       <= high_byte_next;
      transfer_failed <= transfer_failed_next;
      messages_seen   <= messages_seen_next;
      success_total   <= success_total_next;
      failure_total   <= failure_total_next;
    end
  end

  // ---------------- byte store ----------------
  store_cmd_t st_cmd_q;
  assign st_cmd_q.we = st_cmd.we && in_acc;
  assign st_cmd_q.re = st_cmd.re && in_acc;

  i2cmtrw_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .rst   (rst),
    .cmd   (st_cmd_q),
    .addr  (st_addr),
    .wdata (data_byte),
    .rdata (st_rdata),
    .ready (st_ready)
  );

  // ---------------- sequencing and result register ----------------
  always_ff @(posedge clk) begin
    if (in_acc) begin
      resp_status <= status;
      resp_done   <= done;
      resp_ok     <= ok;
      resp_rd     <= rd_hit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_state <= ST_IDLE;
    end else begin
      unique case (run_state)
        ST_IDLE: if (in_acc) run_state <= ST_RESP;
        ST_RESP: run_state <= ST_IDLE;
        default: run_state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (run_state == ST_RESP) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (run_state == ST_RESP) begin
      out_byte   <= resp_rd ? st_rdata : 8'h00;
      out_status <= resp_status;
      out_done   <= resp_done;
      out_ok     <= resp_ok;
      out_succ   <= success_total;
      out_fail   <= failure_total;
    end
  end

  assign m_tdata = {5'b0, out_fail, out_succ, out_ok, out_status, out_byte};
  assign m_tlast = out_done;

  // ---------------- assertions ----------------
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (run_state == ST_RESP) && !s_tready)
    else $error("request accepted without a result cycle");

  a_valid_from_resp: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(run_state == ST_RESP))
    else $error("result shown without a preceding request");

  a_one_count: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (func == FN_END_XFER)) |=>
      (32'(success_total - $past(success_total))
       + 32'(failure_total - $past(failure_total))) == 32'd1)
    else $error("transfer end did not count exactly once");

  a_xfer_clears: assert property (@(posedge clk) disable iff (rst)
    (in_acc && (func == FN_END_XFER)) |=>
      !message_open && !transfer_failed && !messages_seen)
    else $error("transfer end left message state behind");

endmodule

// ----- dv/i2c_multi_target_register_window_unit_tb.sv -----
// Self-checking testbench for the multi-target I2C register window unit.
`timescale 1ns / 1ps
module i2c_multi_target_register_window_unit_tb;
  import i2cmtrw_pkg::*;

  localparam int          CYCLE_LIMIT  = 400000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          NUM_PHASES   = 7;
  localparam int          NUM_ROWS     = 32;
  localparam logic [9:0]  DEV0_ADDR    = 10'h050;
  localparam logic [9:0]  DEV1_ADDR    = 10'h3FF;
  localparam logic [9:0]  STRAY_ADDR   = 10'h123;

  typedef struct {
    logic [7:0]  rbyte;
    status_t     st;
    logic        done;
    logic        ok;
    logic [31:0] good_count;
    logic [31:0] bad_count;
  } response_t;

  typedef struct packed {
    logic [2:0] fn;
    logic [9:0] addr;
    logic       rd;
    logic [7:0] data;
    logic       typed;
    status_t    st;
  } request_row_t;

  logic              clk;
  logic              rst;
  logic              s_tvalid;
  logic              s_tready;
  logic [23:0]       s_tdata;  // target_address[9:0], is_read[10], data_byte[18:11]
  logic [2:0]        s_tuser;  // func[2:0]
  logic              m_tvalid;
  logic              m_tready;
  logic [79:0]       m_tdata;  // read_byte[7:0], item_status[9:8], transfer_ok[10],
                               // success_count[42:11], failure_count[74:43]
  logic              m_tlast;  // transfer_done
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [CFG_AW-1:0] paddr;
  logic [CFG_DW-1:0] pwdata;
  logic [CFG_DW-1:0] prdata;
  logic              pready;

  i2c_multi_target_register_window_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // Configuration copy
  logic [1:0]  cfg_dev_count;
  logic [9:0]  cfg_addr [2];
  logic [15:0] cfg_base [2];
  logic [8:0]  cfg_size [2];

  // Device state copy
  logic [7:0]  store_model [512];
  logic [15:0] ptr_model [2];
  logic        msg_open, msg_reading, cur_dev, xfer_failed, msg_seen;
  logic [16:0] byte_pos;
  logic [7:0]  hi_ptr;
  logic [31:0] ok_total, bad_total;

  response_t   awaited_responses [$];
  logic        pin_typed;
  status_t     pin_status;
  logic        quiet, hold_request;
  int unsigned requests_sent, settings_applied, mismatches, cycle_count;

  request_row_t directed_rows [NUM_ROWS] = '{
    '{FN_END_XFER, 10'h000,     1'b0, 8'h00, 1'b1, STAT_FAIL},     // empty transfer
    '{FN_START,    STRAY_ADDR,  1'b0, 8'h00, 1'b1, STAT_FAIL},     // unknown address
    '{FN_END_XFER, 10'h000,     1'b0, 8'h00, 1'b1, STAT_IGNORED},
    '{FN_START,    DEV0_ADDR,   1'b0, 8'h00, 1'b1, STAT_OK},
    '{FN_WRITE,    10'h000,     1'b0, 8'h00, 1'b0, STAT_OK},
    '{FN_WRITE,    10'h000,     1'b0, 8'h10, 1'b0, STAT_OK},       // pointer at window base
    '{FN_WRITE,    10'h000,     1'b0, 8'hFF, 1'b1, STAT_OK},
    '{FN_WRITE,    10'h000,     1'b0, 8'h00, 1'b1, STAT_OK},
    '{FN_END_MSG,  10'h000,     1'b0, 8'h00, 1'b1, STAT_OK},
    '{FN_START,    DEV0_ADDR,   1'b1, 8'h00, 1'b1, STAT_OK},
    '{FN_END_MSG,  10'h000,     1'b0, 8'h00, 1'b1, STAT_OK},       // empty read
    '{FN_END_XFER, 10'h000,     1'b0, 8'h00, 1'b1, STAT_OK},
    '{FN_START,    DEV1_ADDR,   1'b0, 8'h00, 1'b0, STAT_OK},
    '{FN_WRITE,    10'h000,     1'b0, 8'hFF, 1'b0, STAT_OK},
    '{FN_WRITE,    10'h000,     1'b0, 8'hFF, 1'b0, STAT_OK},       // pointer 0xFFFF
    '{FN_WRITE,    10'h000,     1'b0, 8'h5A, 1'b0, STAT_OK},
    '{FN_WRITE,    10'h000,     1'b0, 8'h01, 1'b1, STAT_FAIL},     // past 16-bit top
    '{FN_END_XFER, 10'h000,     1'b0, 8'h00, 1'b1, STAT_IGNORED},
    '{FN_START,    DEV1_ADDR,   1'b1, 8'h00, 1'b0, STAT_OK},
    '{FN_READ,     10'h000,     1'b0, 8'h00, 1'b0, STAT_OK},
    '{FN_WRITE,    10'h000,     1'b0, 8'h33, 1'b1, STAT_FAIL},     // wrong direction
    '{FN_END_XFER, 10'h000,     1'b0, 8'h00, 1'b1, STAT_IGNORED},
    '{FN_READ,     10'h000,     1'b0, 8'h00, 1'b1, STAT_FAIL},     // no open message
    '{FN_END_XFER, 10'h000,     1'b0, 8'h00, 1'b1, STAT_IGNORED},
    '{FN_START,    DEV0_ADDR,   1'b0, 8'h00, 1'b0, STAT_OK},
    '{FN_END_MSG,  10'h000,     1'b0, 8'h00, 1'b1, STAT_FAIL},     // short write
    '{FN_END_XFER, 10'h000,     1'b0, 8'h00, 1'b1, STAT_IGNORED},
    '{FN_START,    DEV0_ADDR,   1'b0, 8'h00, 1'b0, STAT_OK},
    '{FN_START,    DEV0_ADDR,   1'b1, 8'h00, 1'b1, STAT_FAIL},     // start while open
    '{FN_END_XFER, 10'h000,     1'b0, 8'h00, 1'b1, STAT_IGNORED},
    '{FN_START,    DEV1_ADDR,   1'b1, 8'h00, 1'b0, STAT_OK},
    '{FN_END_XFER, 10'h000,     1'b0, 8'h00, 1'b1, STAT_FAIL}      // unfinished message
  };

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Store index for pointer+k of the current device, if inside its window.
  function automatic bit window_slot(logic [16:0] k, output int unsigned slot);
    int unsigned regn, lim, off;
    regn = 32'(ptr_model[cur_dev]) + 32'(k);
    lim = (cfg_size[cur_dev] > 9'd256) ? 32'd256 : 32'(cfg_size[cur_dev]);
    if (regn < 32'(cfg_base[cur_dev])) return 1'b0;
    off = regn - 32'(cfg_base[cur_dev]);
    if (off >= lim) return 1'b0;
    slot = 32'(cur_dev) * 32'd256 + off;
    return 1'b1;
  endfunction

  function automatic response_t window_response(logic [2:0] fn, logic [9:0] addr,
                                                logic rd, logic [7:0] data);
    response_t   r;
    logic        fail;
    logic        d;
    int          n;
    int unsigned slot;
    r.rbyte = 8'h00;
    r.st    = STAT_OK;
    r.done  = 1'b0;
    r.ok    = 1'b0;
    fail    = 1'b0;
    d       = cur_dev;
    if (fn == FN_END_XFER) begin
      r.done = 1'b1;
      if (xfer_failed) r.st = STAT_IGNORED;
      else if (!msg_seen || msg_open) r.st = STAT_FAIL;
      else r.ok = 1'b1;
      if (r.ok) ok_total++;
      else bad_total++;
      msg_open    = 1'b0;
      msg_reading = 1'b0;
      byte_pos    = '0;
      xfer_failed = 1'b0;
      msg_seen    = 1'b0;
    end else if (xfer_failed) begin
      r.st = STAT_IGNORED;
    end else begin
      case (fn)
        FN_START: begin
          msg_seen = 1'b1;
          if (msg_open) begin
            fail = 1'b1;
          end else begin
            n = (cfg_dev_count > 2'd2) ? 2 : int'(cfg_dev_count);
            fail = 1'b1;
            // walk down so the lowest matching device wins
            for (int i = n - 1; i >= 0; i--) begin
              if (cfg_addr[i] == addr) begin
                cur_dev = i[0];
                fail = 1'b0;
              end
            end
            if (!fail) begin
              msg_open    = 1'b1;
              msg_reading = rd;
              byte_pos    = '0;
            end
          end
        end
        FN_WRITE: begin
          if (!msg_open || msg_reading) fail = 1'b1;
          else if (byte_pos == 0) hi_ptr = data;
          else if (byte_pos == 1) ptr_model[d] = {hi_ptr, data};
          else if (window_slot(byte_pos - 17'd2, slot)) store_model[slot] = data;
          else fail = 1'b1;
          if (!fail && byte_pos != '1) byte_pos++;
        end
        FN_READ: begin
          if (!msg_open || !msg_reading || !window_slot(byte_pos, slot)) begin
            fail = 1'b1;
          end else begin
            r.rbyte = store_model[slot];
            if (byte_pos != '1) byte_pos++;
          end
        end
        FN_END_MSG: begin
          if (!msg_open || (!msg_reading && byte_pos < 2)) begin
            fail = 1'b1;
          end else begin
            if (msg_reading) ptr_model[d] = ptr_model[d] + byte_pos[15:0];
            else ptr_model[d] = ptr_model[d] + 16'(byte_pos - 17'd2);
            msg_open = 1'b0;
            byte_pos = '0;
          end
        end
        default: fail = 1'b1;
      endcase
      if (fail) begin
        r.st        = STAT_FAIL;
        xfer_failed = 1'b1;
        msg_open    = 1'b0;
      end
    end
    r.good_count = ok_total;
    r.bad_count  = bad_total;
    return r;
  endfunction

  always @(posedge clk) begin
    response_t want;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (awaited_responses.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("ERROR: response %h with none awaited", m_tdata);
        end else begin
          want = awaited_responses.pop_front();
          if (m_tdata[7:0] !== want.rbyte || m_tdata[9:8] !== want.st ||
              m_tdata[10] !== want.ok || m_tlast !== want.done ||
              m_tdata[42:11] !== want.good_count || m_tdata[74:43] !== want.bad_count) begin
            mismatches++;
            if (mismatches <= 10)
              $display("ERROR: exp byte %h st %0d done %b ok %b good %0d bad %0d / got %h %0d %b %b %0d %0d",
                       want.rbyte, want.st, want.done, want.ok, want.good_count,
                       want.bad_count, m_tdata[7:0], m_tdata[9:8], m_tlast, m_tdata[10],
                       m_tdata[42:11], m_tdata[74:43]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        want = window_response(s_tuser, s_tdata[9:0], s_tdata[10], s_tdata[18:11]);
        if (pin_typed) want.st = pin_status;
        awaited_responses.push_back(want);
      end
    end
  end

  // Result side: short random stalls, one long hold-off on request, none at the tail
  initial begin
    m_tready = 1'b0;
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_request) begin
        m_tready = 1'b0;
        for (int i = 0; i < HOLD_CYCLES; i++) @(negedge clk);
        hold_request = 1'b0;
        m_tready = 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        m_tready = 1'b0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
        m_tready = 1'b1;
      end else begin
        m_tready = 1'b1;
        repeat ($urandom_range(0, 20)) @(negedge clk);
      end
    end
  end

  task automatic write_register(logic [2:0] idx, logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {idx, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    case (idx)
      REG_DEVICE_COUNT: cfg_dev_count = value[1:0];
      REG_DEV0_ADDRESS: cfg_addr[0]   = value[9:0];
      REG_DEV0_BASE:    cfg_base[0]   = value[15:0];
      REG_DEV0_SIZE:    cfg_size[0]   = value[8:0];
      REG_DEV1_ADDRESS: cfg_addr[1]   = value[9:0];
      REG_DEV1_BASE:    cfg_base[1]   = value[15:0];
      REG_DEV1_SIZE:    cfg_size[1]   = value[8:0];
      default: ;
    endcase
  endtask

  task automatic apply_setting(logic [1:0] cnt, logic [9:0] a0, logic [15:0] b0,
                               logic [8:0] z0, logic [9:0] a1, logic [15:0] b1,
                               logic [8:0] z1);
    // only while nothing is in flight
    while (awaited_responses.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    write_register(REG_DEVICE_COUNT, 32'(cnt));
    write_register(REG_DEV0_ADDRESS, 32'(a0));
    write_register(REG_DEV0_BASE, 32'(b0));
    write_register(REG_DEV0_SIZE, 32'(z0));
    write_register(REG_DEV1_ADDRESS, 32'(a1));
    write_register(REG_DEV1_BASE, 32'(b1));
    write_register(REG_DEV1_SIZE, 32'(z1));
    settings_applied++;
  endtask

  // Fields a request kind does not use carry random values.
  task automatic send_request(logic [2:0] fn, logic [9:0] addr = '0, logic rd = 1'b0,
                              logic [7:0] data = '0, logic typed = 1'b0,
                              status_t st = STAT_OK);
    if (fn != FN_START) begin
      addr = 10'($urandom);
      rd   = 1'($urandom);
    end
    if (fn != FN_WRITE) data = 8'($urandom);
    if (!quiet && $urandom_range(0, 5) == 0) repeat ($urandom_range(1, 7)) @(negedge clk);
    s_tvalid   = 1'b1;
    s_tuser    = fn;
    s_tdata    = {5'b0, data, rd, addr};
    pin_typed  = typed;
    pin_status = st;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
    s_tvalid  = 1'b0;
    pin_typed = 1'b0;
    requests_sent++;
  endtask

  function automatic logic [15:0] pick_pointer(logic d);
    int unsigned lim;
    lim = (cfg_size[d] > 9'd256) ? 32'd256 : 32'(cfg_size[d]);
    if (lim == 0 || $urandom_range(0, 7) == 0) return 16'($urandom);
    return 16'(32'(cfg_base[d]) + $urandom_range(0, lim - 1));
  endfunction

  task automatic run_transfer();
    int         kind;
    logic       d;
    logic [9:0] a;
    logic [15:0] p;
    if ($urandom_range(0, 9) == 0) begin
      // noise: any kind, any fields, transfer left as it lands
      repeat ($urandom_range(1, 4))
        send_request(3'($urandom_range(0, 7)), 10'($urandom), 1'($urandom), 8'($urandom));
      return;
    end
    repeat ($urandom_range(1, 3)) begin
      d    = 1'($urandom_range(0, 1));
      a    = ($urandom_range(0, 15) == 0) ? 10'($urandom) : cfg_addr[d];
      kind = $urandom_range(0, 11);
      p    = pick_pointer(d);
      if (kind < 6) begin
        send_request(FN_START, a, 1'b0);
        send_request(FN_WRITE, , , p[15:8]);
        send_request(FN_WRITE, , , p[7:0]);
        repeat ($urandom_range(0, 6)) send_request(FN_WRITE, , , 8'($urandom));
        if ($urandom_range(0, 15) != 0) send_request(FN_END_MSG);
      end else if (kind < 10) begin
        send_request(FN_START, a, 1'b0);
        send_request(FN_WRITE, , , p[15:8]);
        send_request(FN_WRITE, , , p[7:0]);
        send_request(FN_END_MSG);
        send_request(FN_START, a, 1'b1);
        repeat ($urandom_range(0, 6)) send_request(FN_READ);
        send_request(FN_END_MSG);
      end else begin
        case ($urandom_range(0, 2))
          0: begin
            send_request(FN_START, a, 1'b0);
            if ($urandom_range(0, 1)) send_request(FN_WRITE, , , 8'($urandom));
            send_request(FN_END_MSG);
          end
          1: begin
            send_request(FN_START, a, 1'b1);
            send_request(FN_WRITE, , , 8'($urandom));
          end
          default: begin
            send_request(FN_START, a, 1'($urandom));
            send_request(FN_START, a, 1'($urandom));
          end
        endcase
      end
    end
    send_request(FN_END_XFER);
  endtask

  initial begin
    int unsigned phase_end;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    s_tuser       = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    pin_typed     = 1'b0;
    pin_status    = STAT_OK;
    quiet         = 1'b0;
    hold_request  = 1'b0;
    requests_sent = 0;
    settings_applied = 0;
    mismatches    = 0;
    cfg_dev_count = '0;
    cfg_addr      = '{default: '0};
    cfg_base      = '{default: '0};
    cfg_size      = '{default: '0};
    foreach (store_model[i]) store_model[i] = 8'h00;
    ptr_model     = '{default: '0};
    msg_open      = 1'b0;
    msg_reading   = 1'b0;
    cur_dev       = 1'b0;
    xfer_failed   = 1'b0;
    msg_seen      = 1'b0;
    byte_pos      = '0;
    hi_ptr        = '0;
    ok_total      = '0;
    bad_total     = '0;
    rst = 1'b1;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    apply_setting(2'd2, DEV0_ADDR, 16'h0010, 9'd16, DEV1_ADDR, 16'hFF00, 9'd256);
    foreach (directed_rows[i])
      send_request(directed_rows[i].fn, directed_rows[i].addr, directed_rows[i].rd,
                   directed_rows[i].data, directed_rows[i].typed, directed_rows[i].st);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: apply_setting(2'd2, DEV0_ADDR, 16'h0010, 9'd16, DEV1_ADDR, 16'hFF00, 9'd256);
        1: apply_setting(2'd1, 10'h000, 16'h0000, 9'd256, 10'h2A5, 16'h1000, 9'd511);
        2: apply_setting(2'd3, 10'h155, 16'hFFFF, 9'd1, 10'h2AA, 16'h8000, 9'd257);
        3: apply_setting(2'd0, DEV0_ADDR, 16'h0000, 9'd256, DEV1_ADDR, 16'h0000, 9'd256);
        default: apply_setting(2'd2, 10'($urandom), 16'($urandom),
                               9'($urandom_range(0, 300)), 10'($urandom), 16'($urandom),
                               9'($urandom_range(0, 300)));
      endcase
      // long result-side hold-off while requests keep coming
      if (phase == 1) hold_request = 1'b1;
      if (phase == NUM_PHASES - 1) quiet = 1'b1;
      phase_end = requests_sent + ((phase == 3) ? 40 : (phase < 3) ? 120 : 160);
      while (requests_sent < phase_end) run_transfer();
    end

    while (awaited_responses.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
    $display("Summary: %0d requests over %0d register settings; %0d transfers good, %0d bad",
             requests_sent, settings_applied, ok_total, bad_total);
    $display("Summary: %0d mismatches in %0d cycles", mismatches, cycle_count);
    if (mismatches == 0 && awaited_responses.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ----- i2c_multi_target_register_window_unit.f -----
rtl/core/i2cmtrw_pkg.sv
rtl/core/i2cmtrw_store.sv
rtl/core/i2c_multi_target_register_window_unit.sv
dv/i2c_multi_target_register_window_unit_tb.sv
